[rtl/core/bfe_pkg.sv]
// Shared field widths and beat payload types for the binary fraction expander.
package bfe_pkg;

  localparam int NUM_W = 6;
  localparam int DEN_W = 7;

  typedef struct packed {
    logic [NUM_W-1:0] numerator;
    logic [DEN_W-1:0] denominator;
  } frac_t;

  typedef struct packed {
    logic digit;
    logic period_start;
    logic last;
    logic error;
  } result_t;

endpackage

[rtl/core/bfe_stream_if.sv]
// Valid/ready stream channel carrying one payload per beat.
interface bfe_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/bfe_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bfe_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/binary_fraction_expander_top.sv]
// Top level: binary expansion of a proper fraction with repeat detection.
//
//   channel   | dir | payload                                   | beats per fraction
//   ----------+-----+-------------------------------------------+-------------------
//   fraction  | in  | numerator[5:0], denominator[6:0]          | 1
//   digits    | out | digit, period_start, last, error          | 1..MAX_DENOMINATOR
//
// Flow: a valid fraction with n digits is accepted, then runs n+1
//   doubling/compare-subtract steps through the single step unit (the last
//   one finds the repeated remainder), then gives n digit beats read from the
//   digit RAM at one per cycle unless digits stalls. n never exceeds the denominator.
// An invalid fraction (zero denominator, numerator not below it, denominator
//   above MAX_DENOMINATOR) gives a single error beat, loaded from the S_ERR state.
// Reset clears the sequencer, the seen-remainder valid bits and the output
//   valid flag; RAM contents are not cleared (valid bits cover the step table).
// A stalled digits channel holds the output register and pauses RAM reads;
//   a new fraction is taken while the last beat of the previous one waits.
module binary_fraction_expander_top #(
  parameter int MAX_DENOMINATOR = 64
) (
  input  logic         clk,
  input  logic         rst,
  bfe_stream_if.sink   fraction,
  bfe_stream_if.source digits
);

  import bfe_pkg::*;

  // RW: remainder / table index width, CW: digit count width (holds n itself)
  localparam int RW   = $clog2(MAX_DENOMINATOR);
  localparam int CW   = $clog2(MAX_DENOMINATOR + 1);
  localparam int CMPW = (RW + 1 > DEN_W) ? RW + 1 : DEN_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ERR    = 4'b0010,
    S_EXPAND = 4'b0100,
    S_EMIT   = 4'b1000
  } state_t;

  state_t state;

  // fraction under work
  logic [RW-1:0]    rem;
  logic [DEN_W-1:0] den;
  logic [CW-1:0]    count;
  logic [MAX_DENOMINATOR-1:0] seen;  // remainder already has a step in the table

  // emit side
  logic [CW-1:0] k;          // next digit index to read
  logic          rd_pend;    // digit RAM read data waiting for the output register
  logic          pend_ps;
  logic          pend_last;

  // output register
  logic    out_valid;
  result_t out_data;

  // ---------------------------------------------------------------------------
  // Input check
  // ---------------------------------------------------------------------------
  logic bad_in;
  logic in_acc;

  assign in_acc = fraction.valid && fraction.ready;
  assign bad_in = (fraction.data.denominator == '0)
               || (DEN_W'(fraction.data.numerator) >= fraction.data.denominator)
               || (32'(fraction.data.denominator) > 32'(MAX_DENOMINATOR));

  assign fraction.ready = (state == S_IDLE);

  // ---------------------------------------------------------------------------
  // Shared step unit: double the remainder, compare-subtract the denominator
  // ---------------------------------------------------------------------------
  logic [CMPW-1:0] twice;
  logic [CMPW-1:0] den_ext;
  logic [CMPW-1:0] diff;
  logic            bit_out;
  logic [RW-1:0]   rem_next;
  logic            hit;

  assign twice    = CMPW'({rem, 1'b0});
  assign den_ext  = CMPW'(den);
  assign bit_out  = (twice >= den_ext);
  assign diff     = bit_out ? (twice - den_ext) : twice;
  assign rem_next = diff[RW-1:0];   // below den, so fits
  assign hit      = seen[rem];

  // ---------------------------------------------------------------------------
  // Step table: step at which each remainder first appeared
  // ---------------------------------------------------------------------------
  logic          step_we;
  logic          step_re;
  logic [RW-1:0] period_idx;

  assign step_we = (state == S_EXPAND) && !hit;
  assign step_re = (state == S_EXPAND) && hit;

  bfe_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_DENOMINATOR)
  ) u_step_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (rem),
    .wdata (count[RW-1:0]),
    .re    (step_re),
    .raddr (rem),
    .rdata (period_idx)
  );

  // ---------------------------------------------------------------------------
  // Digit buffer
  // ---------------------------------------------------------------------------
  logic load;    // pending digit moves into the output register
  logic issue;   // read the next digit
  logic dig_rd;

  assign load  = rd_pend && (!out_valid || digits.ready);
  assign issue = (state == S_EMIT) && (k != count) && (!rd_pend || load);

  bfe_ram #(
    .WIDTH (1),
    .DEPTH (MAX_DENOMINATOR)
  ) u_digit_ram (
    .clk   (clk),
    .we    (step_we),
    .waddr (count[RW-1:0]),
    .wdata (bit_out),
    .re    (issue),
    .raddr (k[RW-1:0]),
    .rdata (dig_rd)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and control registers
  // ---------------------------------------------------------------------------
  logic err_load;
  logic emit_done;

  assign err_load  = (state == S_ERR) && (!out_valid || digits.ready);
  assign emit_done = (state == S_EMIT) && (k == count) && (!rd_pend || load);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k         <= '0;
      seen      <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            if (bad_in) begin
              state <= S_ERR;
            end else begin
              state <= S_EXPAND;
              count <= '0;
              seen  <= '0;
            end
          end
        end
        S_ERR: begin
          if (err_load) begin
            state <= S_IDLE;
          end
        end
        S_EXPAND: begin
          if (hit) begin
            // table read of the repeat's step issued this cycle
            state <= S_EMIT;
            k     <= '0;
          end else begin
            seen[rem] <= 1'b1;
            count     <= count + CW'(1);
          end
        end
        S_EMIT: begin
          if (issue) begin
            k <= k + CW'(1);
          end
          if (emit_done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (issue) begin
        rd_pend <= 1'b1;
      end else if (load) begin
        rd_pend <= 1'b0;
      end

      if (load || err_load) begin
        out_valid <= 1'b1;
      end else if (digits.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_acc) begin
      rem <= RW'(fraction.data.numerator);
      den <= fraction.data.denominator;
    end else if (state == S_EXPAND && !hit) begin
      rem <= rem_next;
    end

    if (issue) begin
      pend_ps   <= (k == CW'(period_idx));
      pend_last <= ((k + CW'(1)) == count);
    end

    if (load) begin
      out_data.digit        <= dig_rd;
      out_data.period_start <= pend_ps;
      out_data.last         <= pend_last;
      out_data.error        <= 1'b0;
    end else if (err_load) begin
      out_data.digit        <= 1'b0;
      out_data.period_start <= 1'b0;
      out_data.last         <= 1'b1;
      out_data.error        <= 1'b1;
    end
  end

  assign digits.valid = out_valid;
  assign digits.data  = out_data;

endmodule

[tb/sv/tb_binary_fraction_expander_top.sv]
// Testbench for binary_fraction_expander_top: directed and random fractions vs. a local predictor.
`timescale 1ns / 1ps

module tb_binary_fraction_expander_top;
  import bfe_pkg::*;

  // Largest denominator the block accepts; passed to the DUT so both sides agree.
  localparam int MAX_DEN = 64;
  // Quiet cycles after the last expected beat, enough for one full expansion.
  localparam int TAIL_CYCLES = 2 * MAX_DEN + 8;

  logic clk;
  logic rst;

  bfe_stream_if #(.payload_t(frac_t))   fraction_ch ();
  bfe_stream_if #(.payload_t(result_t)) digits_ch ();

  binary_fraction_expander_top #(
    .MAX_DENOMINATOR(MAX_DEN)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .fraction(fraction_ch),
    .digits  (digits_ch)
  );

  // Predictor state: its own copy of the step table, digit store and remainder.
  int unsigned seen_at [MAX_DEN];
  bit          digit_store [MAX_DEN];
  int unsigned rem_now;
  int unsigned ndigits_now;

  // Digit beats predicted but not yet seen on the output, oldest first.
  result_t pending_digits [$];

  // Idle rates in percent for each side; 0 means a clean stretch.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  // Long receiver hold-off, picked up by the sink process at its next falling edge.
  int unsigned hold_request;

  // Run bookkeeping.
  int unsigned err_count;
  int unsigned fractions_sent;
  int unsigned invalid_sent;
  int unsigned beats_seen;
  int unsigned period_marks;
  int unsigned longest_expansion;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Append one predicted beat at the tail of the queue.
  function automatic void queue_beat(input result_t r);
    pending_digits = {pending_digits, r};
  endfunction

  // Expand one accepted fraction and queue the digit beats it must produce.
  // Invalid input gives one error beat and leaves the predictor state alone.
  function automatic void expand_fraction(input frac_t f);
    int unsigned num;
    int unsigned den;
    int unsigned cut;
    bit          hit;
    result_t     r;
    num = f.numerator;
    den = f.denominator;
    cut = 0;
    hit = 1'b0;
    if (den == 0 || num >= den || den > MAX_DEN) begin
      r.digit        = 1'b0;
      r.period_start = 1'b0;
      r.last         = 1'b1;
      r.error        = 1'b1;
      queue_beat(r);
      invalid_sent++;
      return;
    end
    foreach (seen_at[i]) seen_at[i] = 0;
    rem_now     = num;
    ndigits_now = 0;
    // Double and compare-subtract until a remainder comes back.
    while (!hit && ndigits_now < MAX_DEN) begin
      if (seen_at[rem_now] != 0) begin
        cut = seen_at[rem_now] - 1;
        hit = 1'b1;
      end else begin
        seen_at[rem_now] = ndigits_now + 1;
        if (rem_now * 2 >= den) begin
          digit_store[ndigits_now] = 1'b1;
          rem_now = rem_now * 2 - den;
        end else begin
          digit_store[ndigits_now] = 1'b0;
          rem_now = rem_now * 2;
        end
        ndigits_now++;
      end
    end
    // Table full without a repeat: cannot happen for den <= MAX_DEN, kept for parity.
    if (!hit && ndigits_now > 0)
      cut = (seen_at[rem_now % MAX_DEN] == 0) ? 0 : seen_at[rem_now % MAX_DEN] - 1;
    for (int unsigned k = 0; k < ndigits_now; k++) begin
      r.digit        = digit_store[k];
      r.period_start = (k == cut);
      r.last         = (k + 1 == ndigits_now);
      r.error        = 1'b0;
      queue_beat(r);
    end
    if (ndigits_now > longest_expansion) longest_expansion = ndigits_now;
  endfunction

  // Offer one fraction, with random idle cycles first; returns at the accepting edge.
  // valid stays high afterwards so back-to-back beats need no low cycle.
  task automatic send_fraction(input frac_t f);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      fraction_ch.valid <= 1'b0;
      @(negedge clk);
    end
    fraction_ch.valid <= 1'b1;
    fraction_ch.data  <= f;
    do @(posedge clk); while (!fraction_ch.ready);
    expand_fraction(f);
    fractions_sent++;
  endtask

  task automatic send_pair(input int unsigned num, input int unsigned den);
    frac_t f;
    f.numerator   = num[NUM_W-1:0];
    f.denominator = den[DEN_W-1:0];
    send_fraction(f);
  endtask

  // Drop valid and wait until every predicted beat has come out.
  task automatic wait_drained();
    @(negedge clk);
    fraction_ch.valid <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk);
  endtask

  // Mostly well-formed fractions, many with small denominators, plus invalid noise.
  function automatic frac_t random_fraction();
    frac_t       f;
    int unsigned sel;
    int unsigned num;
    int unsigned den;
    sel = $urandom_range(99);
    if (sel < 15) begin
      den = $urandom_range(8, 1);
      num = $urandom_range(den - 1, 0);
    end else if (sel < 75) begin
      den = $urandom_range(MAX_DEN, 1);
      num = $urandom_range(den - 1, 0);
    end else if (sel < 85) begin
      // unconstrained: covers denominators above the limit and all high bits
      num = $urandom_range(63, 0);
      den = $urandom_range(127, 0);
    end else if (sel < 90) begin
      num = $urandom_range(63, 0);
      den = 0;
    end else begin
      // numerator at or above the denominator
      num = $urandom_range(63, 0);
      den = (num == 0) ? 0 : $urandom_range(num, 1);
    end
    f.numerator   = num[NUM_W-1:0];
    f.denominator = den[DEN_W-1:0];
    return f;
  endfunction

  // Digits sink: random stalls, plus a long hold-off when a test asks for one.
  initial begin : digits_sink
    int unsigned hold_left;
    hold_left       = 0;
    digits_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        digits_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        digits_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        digits_ch.ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Beat checker: every accepted output beat is matched against the oldest prediction.
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && digits_ch.valid && digits_ch.ready) begin
      got = digits_ch.data;
      beats_seen++;
      if (got.period_start) period_marks++;
      if (pending_digits.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got digit=%0b ps=%0b last=%0b err=%0b",
                 $realtime, got.digit, got.period_start, got.last, got.error);
        err_count++;
      end else begin
        want = pending_digits.pop_front();
        if (got.digit !== want.digit) begin
          $display("%0t: digit mismatch, expected %0b, got %0b",
                   $realtime, want.digit, got.digit);
          err_count++;
        end
        if (got.period_start !== want.period_start) begin
          $display("%0t: period_start mismatch, expected %0b, got %0b",
                   $realtime, want.period_start, got.period_start);
          err_count++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last mismatch, expected %0b, got %0b",
                   $realtime, want.last, got.last);
          err_count++;
        end
        if (got.error !== want.error) begin
          $display("%0t: error mismatch, expected %0b, got %0b",
                   $realtime, want.error, got.error);
          err_count++;
        end
      end
    end
  end

  // Valid fractions at the corners: zero numerator, halves, the largest
  // denominator, pure repeats, mixed pre-period plus repeat, long periods.
  task automatic test_edge_fractions();
    send_pair(0, 1);     // zero numerator, smallest denominator
    send_pair(0, 64);    // zero numerator, largest denominator
    send_pair(1, 2);     // terminates right away
    send_pair(1, 3);     // pure repeat 01
    send_pair(1, 64);    // longest run of leading zeros then terminates
    send_pair(63, 64);   // all-ones numerator
    send_pair(5, 6);     // one digit before the repeating part
    send_pair(3, 40);    // several digits before the repeat
    send_pair(1, 63);
    send_pair(1, 59);    // 58-digit period
    send_pair(60, 61);   // 60-digit period, largest numerator under it
    send_pair(42, 43);
    send_pair(21, 22);
  endtask

  // Each way a fraction can be rejected, each giving a single error beat.
  task automatic test_invalid_fractions();
    send_pair(0, 0);     // zero denominator
    send_pair(63, 0);
    send_pair(7, 7);     // numerator equal to denominator
    send_pair(63, 1);    // numerator above denominator
    send_pair(0, 65);    // denominator just past the limit
    send_pair(63, 127);  // largest denominator field
    send_pair(0, 127);
    send_pair(1, 1);     // only denominator 1 fraction is 0/1
  endtask

  task automatic test_random_mix(input int unsigned count, input int unsigned idle_pct);
    send_idle_pct = idle_pct;
    recv_idle_pct = idle_pct;
    repeat (count) send_fraction(random_fraction());
  endtask

  // Receiver holds off long enough that the block fills and stops taking fractions.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 8;
    hold_request  = 400;
    repeat (40) send_fraction(random_fraction());
  endtask

  // Sender stops until every beat is out, then resumes with a few more.
  task automatic test_drain_pause();
    wait_drained();
    send_idle_pct = 8;
    recv_idle_pct = 8;
    repeat (20) send_fraction(random_fraction());
  endtask

  initial begin
    rst               = 1'b1;
    fraction_ch.valid = 1'b0;
    fraction_ch.data  = '0;
    send_idle_pct     = 8;
    recv_idle_pct     = 8;
    hold_request      = 0;
    err_count         = 0;
    fractions_sent    = 0;
    invalid_sent      = 0;
    beats_seen        = 0;
    period_marks      = 0;
    longest_expansion = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_fractions();
    test_invalid_fractions();
    test_random_mix(60, 0);    // clean stretch, no idling on either side
    test_random_mix(240, 8);
    test_output_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d fractions (%0d rejected), %0d digit beats, %0d period marks",
             fractions_sent, invalid_sent, beats_seen, period_marks);
    $display("longest expansion %0d digits, with stalls, a long output hold and a drain pause",
             longest_expansion);
    if (err_count == 0) begin
      $display("tb_binary_fraction_expander_top: done, clean");
    end else begin
      $display("tb_binary_fraction_expander_top: done, errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1_000_000;
    $display("tb_binary_fraction_expander_top: done, errors");
    $finish;
  end

endmodule
